### rtl/bcomp_pkg.sv
// bcomp_pkg: shared types and constants for the barometer compensation block
// holds payload structs, calibration struct, queue entry format and fixed widths
// no dependencies
package bcomp_pkg;

  // queue between front and back
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CAL   = 2'd0,
    REG_PRESS_LOW  = 2'd1,
    REG_PRESS_MID  = 2'd2,
    REG_PRESS_HIGH = 2'd3
  } cfg_reg_t;

  // datapath widths
  localparam int TQ_W  = 28;   // unsaturated temperature, 16 fraction bits
  localparam int C3_W  = 36;   // cubic coefficient
  localparam int C2_W  = 56;   // quadratic coefficient
  localparam int C1_W  = 88;   // linear coefficient
  localparam int C0_W  = 112;  // constant coefficient
  localparam int MA_W  = 96;   // multiplicand of the horner mac
  localparam int ACC_W = 128;  // horner accumulator

  // offsets and rounding constants
  localparam logic signed [16:0]      P_OFFSET   = 17'sd16384;
  localparam logic signed [62:0]      TEMP_HALF  = 63'sh0000_0000_8000_0000;
  localparam logic signed [ACC_W-1:0] PRESS_HALF = 128'sd1 <<< 78;
  localparam logic signed [23:0]      TEMP_MAX   = 24'sh7F_FFFF;
  localparam logic signed [23:0]      TEMP_MIN   = 24'sh80_0000;
  localparam logic [23:0]             PRESS_MAX  = 24'hFF_FFFF;

  typedef struct packed {
    logic [23:0] raw_temp;
    logic [23:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] temperature;
    logic [23:0]        pressure;
    logic               out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [39:0] temp_cal_word;
    logic [47:0] press_cal_low;
    logic [47:0] press_cal_mid;
    logic [31:0] press_cal_high;
  } cal_t;

  // one queue entry: temperature result plus the pressure polynomial in t
  typedef struct packed {
    logic signed [TQ_W-1:0] tq;
    logic signed [23:0]     tout;
    logic                   tflag;
    logic signed [C3_W-1:0] c3;
    logic signed [C2_W-1:0] c2;
    logic signed [C1_W-1:0] c1;
    logic signed [C0_W-1:0] c0;
  } q_entry_t;

endpackage

### rtl/bcomp_front.sv
// bcomp_front: five-stage front pipeline, linearised temperature and
// the raw-pressure dependent coefficients of the pressure cubic in t
// depends on bcomp_pkg
module bcomp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  bcomp_pkg::in_item_t in_item,
  input  bcomp_pkg::cal_t     cal,
  output logic                push,
  output bcomp_pkg::q_entry_t entry
);
  import bcomp_pkg::*;

  // calibration fields
  logic [15:0]        t1, t2, p5, p6;
  logic signed [7:0]  t3, p3, p4, p7, p8, p10, p11;
  logic signed [15:0] p1, p2, p9;
  logic signed [16:0] p1o, p2o;

  assign t1  = cal.temp_cal_word[15:0];
  assign t2  = cal.temp_cal_word[31:16];
  assign t3  = $signed(cal.temp_cal_word[39:32]);
  assign p1  = $signed(cal.press_cal_low[15:0]);
  assign p2  = $signed(cal.press_cal_low[31:16]);
  assign p3  = $signed(cal.press_cal_low[39:32]);
  assign p4  = $signed(cal.press_cal_low[47:40]);
  assign p5  = cal.press_cal_mid[15:0];
  assign p6  = cal.press_cal_mid[31:16];
  assign p7  = $signed(cal.press_cal_mid[39:32]);
  assign p8  = $signed(cal.press_cal_mid[47:40]);
  assign p9  = $signed(cal.press_cal_high[15:0]);
  assign p10 = $signed(cal.press_cal_high[23:16]);
  assign p11 = $signed(cal.press_cal_high[31:24]);
  assign p1o = $signed({p1[15], p1}) - P_OFFSET;
  assign p2o = $signed({p2[15], p2}) - P_OFFSET;

  logic [3:0] vld;

  // stage 0: captured sample
  logic [23:0] rt0, rp0;

  // stage 1: temperature offset and pressure squared
  logic signed [25:0] d1, d1_next;
  logic [23:0]        rp1;
  logic [47:0]        wp2_1, wp2_next;

  assign d1_next  = $signed({2'b00, rt0}) - $signed({2'b00, t1, 8'h00});
  assign wp2_next = rp0 * rp0;

  // stage 2: first products
  logic signed [24:0] rps;
  logic signed [48:0] wp2s;
  logic signed [42:0] dt2_w;
  logic signed [51:0] dd_w;
  logic signed [35:0] rp_p4;
  logic signed [32:0] rp_p3;
  logic signed [41:0] rp_p2, rp_p1;
  logic signed [56:0] wp2_p10;
  logic signed [64:0] wp2_p9;
  logic [47:0]        wp3_hi, wp3_lo;
  logic signed [C3_W-1:0] c3_next;
  logic signed [C2_W-1:0] c2_next;

  assign rps     = $signed({1'b0, rp1});
  assign wp2s    = $signed({1'b0, wp2_1});
  assign dt2_w   = d1 * $signed({1'b0, t2});
  assign dd_w    = d1 * d1;
  assign rp_p4   = rps * p4;
  assign rp_p3   = rps * p3;
  assign rp_p2   = rps * p2o;
  assign rp_p1   = rps * p1o;
  assign wp2_p10 = wp2s * p10;
  assign wp2_p9  = wp2s * p9;
  assign wp3_hi  = wp2_1[47:24] * rp1;
  assign wp3_lo  = wp2_1[23:0] * rp1;
  assign c3_next = $signed({{6{p8[7]}}, p8, 22'b0}) + rp_p4;
  assign c2_next = $signed({{3{p7[7]}}, p7, 45'b0})
                 + $signed({{2{rp_p3[32]}}, rp_p3, 21'b0});

  logic signed [42:0]     dt2_2;
  logic signed [49:0]     dd2;
  logic signed [C3_W-1:0] c3_2;
  logic signed [C2_W-1:0] c2_2;
  logic signed [41:0]     rp_p2_2, rp_p1_2;
  logic signed [56:0]     wp2_p10_2;
  logic signed [64:0]     wp2_p9_2;
  logic [47:0]            wp3_hi2, wp3_lo2;

  // stage 3: temperature numerator, linear coefficient, partial constant
  logic signed [57:0]     dd_t3;
  logic signed [61:0]     tn_next;
  logic signed [C1_W-1:0] c1_next;
  logic signed [C0_W-1:0] c0a_next;
  logic [71:0]            wp3_next;

  assign dd_t3    = dd2 * t3;
  assign tn_next  = $signed({dt2_2[42], dt2_2, 18'b0}) + dd_t3;
  assign c1_next  = $signed({9'b0, p6, 63'b0})
                  + $signed({{6{rp_p2_2[41]}}, rp_p2_2, 40'b0})
                  + $signed({{10{wp2_p10_2[56]}}, wp2_p10_2, 21'b0});
  assign c0a_next = $signed({8'b0, p5, 88'b0})
                  + $signed({{5{rp_p1_2[41]}}, rp_p1_2, 65'b0})
                  + $signed({{10{wp2_p9_2[64]}}, wp2_p9_2, 37'b0});
  assign wp3_next = {wp3_hi2, 24'b0} + {24'b0, wp3_lo2};

  logic signed [61:0]     tn3;
  logic signed [C3_W-1:0] c3_3;
  logic signed [C2_W-1:0] c2_3;
  logic signed [C1_W-1:0] c1_3;
  logic signed [C0_W-1:0] c0a_3;
  logic [71:0]            wp3_3;

  // stage 4: rounding of t, saturation, cubic pressure term
  logic signed [62:0]     tn_r;
  logic signed [TQ_W-1:0] tq_w;
  logic                   t_ovf;
  logic signed [23:0]     tout_w;
  logic signed [80:0]     wp3_p11;
  logic signed [C0_W-1:0] c0_next;

  assign tn_r    = $signed({tn3[61], tn3}) + TEMP_HALF;
  assign tq_w    = tn_r[59:32];
  assign t_ovf   = !((tq_w[27:23] == 5'b00000) || (tq_w[27:23] == 5'b11111));
  assign tout_w  = t_ovf ? (tq_w[TQ_W-1] ? TEMP_MIN : TEMP_MAX) : tq_w[23:0];
  assign wp3_p11 = $signed({1'b0, wp3_3}) * p11;
  assign c0_next = c0a_3 + $signed({{11{wp3_p11[80]}}, wp3_p11, 20'b0});

  // valid line, no stall inside the front
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      push <= 1'b0;
    end else begin
      vld  <= {vld[2:0], accept};
      push <= vld[3];
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    rt0 <= in_item.raw_temp;
    rp0 <= in_item.raw_pressure;

    d1    <= d1_next;
    rp1   <= rp0;
    wp2_1 <= wp2_next;

    dt2_2     <= dt2_w;
    dd2       <= dd_w[49:0];
    c3_2      <= c3_next;
    c2_2      <= c2_next;
    rp_p2_2   <= rp_p2;
    rp_p1_2   <= rp_p1;
    wp2_p10_2 <= wp2_p10;
    wp2_p9_2  <= wp2_p9;
    wp3_hi2   <= wp3_hi;
    wp3_lo2   <= wp3_lo;

    tn3   <= tn_next;
    c3_3  <= c3_2;
    c2_3  <= c2_2;
    c1_3  <= c1_next;
    c0a_3 <= c0a_next;
    wp3_3 <= wp3_next;

    entry.tq    <= tq_w;
    entry.tout  <= tout_w;
    entry.tflag <= t_ovf;
    entry.c3    <= c3_3;
    entry.c2    <= c2_3;
    entry.c1    <= c1_3;
    entry.c0    <= c0_next;
  end

endmodule

### rtl/bcomp_queue.sv
// bcomp_queue: small register queue between front and back pipelines
// depends on bcomp_pkg
module bcomp_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  bcomp_pkg::q_entry_t       wr_entry,
  input  logic                      pop,
  output bcomp_pkg::q_entry_t       head,
  output logic [bcomp_pkg::QCW-1:0] count
);
  import bcomp_pkg::*;

  q_entry_t       mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;

  assign head = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

endmodule

### rtl/bcomp_mac.sv
// bcomp_mac: two-stage multiply-add, 96-bit by 28-bit signed plus 128-bit addend
// multiplicand split into three 32-bit limbs; depends on bcomp_pkg
module bcomp_mac (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [bcomp_pkg::MA_W-1:0]  a,
  input  logic signed [bcomp_pkg::TQ_W-1:0]  b,
  input  logic signed [bcomp_pkg::ACC_W-1:0] addend,
  output logic signed [bcomp_pkg::ACC_W-1:0] result
);
  import bcomp_pkg::*;

  // limb products
  logic signed [60:0] pp0_w, pp1_w;
  logic signed [59:0] pp2_w;
  logic signed [60:0] pp0, pp1;
  logic signed [59:0] pp2;
  logic signed [ACC_W-1:0] add_d;

  assign pp0_w = $signed({1'b0, a[31:0]}) * b;
  assign pp1_w = $signed({1'b0, a[63:32]}) * b;
  assign pp2_w = $signed(a[95:64]) * b;

  always_ff @(posedge clk) begin
    if (en) begin
      pp0    <= pp0_w;
      pp1    <= pp1_w;
      pp2    <= pp2_w;
      add_d  <= addend;
      result <= $signed({{4{pp2[59]}}, pp2, 64'b0})
              + $signed({{35{pp1[60]}}, pp1, 32'b0})
              + $signed({{67{pp0[60]}}, pp0})
              + add_d;
    end
  end

endmodule

### rtl/bcomp_back.sv
// bcomp_back: horner evaluation of the pressure cubic in t, rounding and clamping
// three bcomp_mac steps and an output register; depends on bcomp_pkg, bcomp_mac
module bcomp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  bcomp_pkg::q_entry_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bcomp_pkg::out_item_t out_item
);
  import bcomp_pkg::*;

  typedef struct packed {
    logic signed [TQ_W-1:0] tq;
    logic signed [23:0]     tout;
    logic                   tflag;
    logic signed [C1_W-1:0] c1;
    logic signed [C0_W-1:0] c0;
  } band_t;

  logic     en;
  logic [6:0] vld;
  q_entry_t s0;
  band_t    band [6];

  logic signed [ACC_W-1:0] acc1, acc2, acc3;

  // whole back pipeline moves unless a finished result is held
  assign en  = !out_valid || !out_stall;
  assign pop = en && head_valid;

  // t*c3 + c2
  bcomp_mac u_mac1 (
    .clk    (clk),
    .en     (en),
    .a      ($signed({{(MA_W - C3_W){s0.c3[C3_W-1]}}, s0.c3})),
    .b      (s0.tq),
    .addend ($signed({{(ACC_W - C2_W){s0.c2[C2_W-1]}}, s0.c2})),
    .result (acc1)
  );

  // (..)*t + c1
  bcomp_mac u_mac2 (
    .clk    (clk),
    .en     (en),
    .a      (acc1[MA_W-1:0]),
    .b      (band[1].tq),
    .addend ($signed({{(ACC_W - C1_W){band[1].c1[C1_W-1]}}, band[1].c1})),
    .result (acc2)
  );

  // (..)*t + c0
  bcomp_mac u_mac3 (
    .clk    (clk),
    .en     (en),
    .a      (acc2[MA_W-1:0]),
    .b      (band[3].tq),
    .addend ($signed({{(ACC_W - C0_W){band[3].c0[C0_W-1]}}, band[3].c0})),
    .result (acc3)
  );

  // rounding to 1/64 Pa and clamping
  logic signed [ACC_W-1:0] n_r;
  logic signed [48:0]      q;
  logic                    p_neg, p_big;
  logic [23:0]             p_w;

  assign n_r   = acc3 + PRESS_HALF;
  assign q     = n_r[127:79];
  assign p_neg = q[48];
  assign p_big = |q[47:24];
  assign p_w   = p_neg ? '0 : (p_big ? PRESS_MAX : q[23:0]);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[5:0], pop};
      out_valid <= vld[6];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= head;
      band[0].tq    <= s0.tq;
      band[0].tout  <= s0.tout;
      band[0].tflag <= s0.tflag;
      band[0].c1    <= s0.c1;
      band[0].c0    <= s0.c0;
      for (int i = 1; i < 6; i++) begin
        band[i] <= band[i-1];
      end
      out_item.temperature  <= band[5].tout;
      out_item.pressure     <= p_w;
      out_item.out_of_range <= band[5].tflag || p_neg || p_big;
    end
  end

endmodule

### rtl/barometer_compensation_top.sv
// Barometer compensation: takes one raw temperature/pressure pair per cycle while
// input stall is low and returns compensated temperature (degC * 65536) and
// pressure (Pa * 64). The path runs through the front, the queue and the back:
// a head register, three chained multiply-add steps that evaluate the pressure
// cubic in t, and the output register. The front never stalls; input stall rises
// when the 8-entry queue plus items still in the front reach its depth, and the
// back freezes while a result is held by output stall.
// Calibration registers are written through the plain write port and reset to zero.
// depends on bcomp_pkg, bcomp_front, bcomp_queue, bcomp_back
module barometer_compensation_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  bcomp_pkg::in_item_t             in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bcomp_pkg::out_item_t            out_item,
  input  logic                            cfg_write_enable,
  input  logic [bcomp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcomp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bcomp_pkg::*;

  cal_t           cal;
  logic           accept, push, pop;
  q_entry_t       wr_entry, head;
  logic [QCW-1:0] q_count, used;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_TEMP_CAL:   cal.temp_cal_word  <= cfg_data[39:0];
        REG_PRESS_LOW:  cal.press_cal_low  <= cfg_data[47:0];
        REG_PRESS_MID:  cal.press_cal_mid  <= cfg_data[47:0];
        REG_PRESS_HIGH: cal.press_cal_high <= cfg_data[31:0];
      endcase
    end
  end

  // credits: items in the front plus items queued
  assign accept   = in_valid && !in_stall;
  assign in_stall = (used == QCW'(QDEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + QCW'(accept) - QCW'(pop);
    end
  end

  bcomp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_item (in_item),
    .cal     (cal),
    .push    (push),
    .entry   (wr_entry)
  );

  bcomp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  bcomp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_count != '0),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

  // credit count never passes the queue depth
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    used <= QCW'(QDEPTH))
    else $error("credit count above queue depth");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_count != QCW'(QDEPTH)))
    else $error("queue overflow");

  // the back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_count != '0))
    else $error("queue underflow");

endmodule
